FILE: rtl/sparse_coordinate_store_core_defines.svh
// Assertion helpers shared by the RTL
`ifndef SPARSE_COORDINATE_STORE_CORE_DEFINES_SVH
`define SPARSE_COORDINATE_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define SCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/scs_pkg.sv
package scs_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF   = 64;
    localparam int COORD_W_DEF = 16;

    // Fixed field widths
    localparam int ROW_W    = 16;
    localparam int COL_W    = 16;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 7;

    // Stream packing
    localparam int ROW_LSB     = 0;
    localparam int COL_LSB     = ROW_LSB + ROW_W;
    localparam int VAL_LSB     = COL_LSB + COL_W;
    localparam int IN_TDATA_W  = VAL_LSB + VAL_W;
    localparam int OUT_PAD_W   = 5;
    localparam int OUT_TDATA_W = VAL_W + STATUS_W + OUT_PAD_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_RESERVED  = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture request, set up scan
        logic scan;     // issue next slot read, compare previous
        logic hit;      // key matched: take value or update slot
        logic miss;     // scan exhausted: not found, insert or full
        logic emit;     // move result into output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic reserved;   // incoming key is (0,0)
        logic match;      // slot under compare holds the key
        logic exhausted;  // no slot left to compare
        logic out_free;   // output register can take a result
    } t_dp_sts;

endpackage

FILE: rtl/scs_ram.sv
module scs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/scs_ctrl.sv
module scs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  scs_pkg::t_dp_sts i_sts,
    output scs_pkg::t_dp_cmd o_cmd
);

    import scs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = i_sts.reserved ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.match || i_sts.exhausted) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.hit  = i_sts.match;
                o_cmd.miss = !i_sts.match && i_sts.exhausted;
            end
            ST_DONE: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/scs_dp.sv
module scs_dp #(
    parameter int DEPTH   = scs_pkg::DEPTH_DEF,
    parameter int COORD_W = scs_pkg::COORD_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scs_pkg::t_dp_cmd                 i_cmd,
    output scs_pkg::t_dp_sts                 o_sts,
    input  logic                             i_cfg_we,
    input  logic [scs_pkg::CAP_W-1:0]        i_cfg_wdata,
    input  logic [scs_pkg::IN_TDATA_W-1:0]   i_req_data,
    input  logic                             i_req_cmd,
    output logic                             o_rsp_valid,
    input  logic                             i_rsp_ready,
    output logic [scs_pkg::OUT_TDATA_W-1:0]  o_rsp_data
);

    import scs_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int SLOT_W = 2 * COORD_W + VAL_W;

    // Request and bookkeeping registers
    logic [CAP_W-1:0]    r_cap;
    logic [CNT_W-1:0]    r_fill;
    logic                r_cmd;
    logic [COORD_W-1:0]  r_row;
    logic [COORD_W-1:0]  r_col;
    logic [VAL_W-1:0]    r_val;
    logic [CNT_W-1:0]    r_ptr;
    logic [CNT_W-1:0]    r_lim;
    logic                r_ins_ok;
    logic                r_chk_vld;
    logic [IDX_W-1:0]    r_chk_idx;
    logic [VAL_W-1:0]    r_res_val;
    logic [STATUS_W-1:0] r_res_sts;
    logic                r_out_vld;
    logic [VAL_W-1:0]    r_out_val;
    logic [STATUS_W-1:0] r_out_sts;

    logic [COORD_W-1:0]  w_in_row;
    logic [COORD_W-1:0]  w_in_col;
    logic [LIM_W-1:0]    w_cap_ext;
    logic [LIM_W-1:0]    w_depth_ext;
    logic [LIM_W-1:0]    w_cap_lim;
    logic [LIM_W-1:0]    w_fill_ext;
    logic [LIM_W-1:0]    w_lim;
    logic                w_issue;
    logic                w_match;
    logic                w_is_set;
    logic [SLOT_W-1:0]   w_rdata;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [COORD_W-1:0]  w_slot_row;
    logic [COORD_W-1:0]  w_slot_col;
    logic [VAL_W-1:0]    w_slot_val;

    // Incoming key, trimmed or extended to the stored coordinate width
    assign w_in_row = COORD_W'(i_req_data[ROW_LSB +: ROW_W]);
    assign w_in_col = COORD_W'(i_req_data[COL_LSB +: COL_W]);

    // Slots searched: min(capacity, DEPTH, filled); filled slots are a prefix
    always_comb begin
        w_cap_ext   = LIM_W'(r_cap);
        w_depth_ext = LIM_W'(DEPTH);
        w_fill_ext  = LIM_W'(r_fill);
        w_cap_lim   = (w_cap_ext > w_depth_ext) ? w_depth_ext : w_cap_ext;
        w_lim       = (w_fill_ext < w_cap_lim) ? w_fill_ext : w_cap_lim;
    end

    // Scan compare on the registered slot read
    assign w_slot_row = w_rdata[COORD_W-1:0];
    assign w_slot_col = w_rdata[2*COORD_W-1:COORD_W];
    assign w_slot_val = w_rdata[SLOT_W-1:2*COORD_W];
    assign w_issue    = i_cmd.scan && (r_ptr < r_lim);
    assign w_match    = r_chk_vld && (w_slot_row == r_row) && (w_slot_col == r_col);
    assign w_is_set   = (r_cmd == CMD_SET);

    // Slot write: update in place on hit, append at fill point on insert
    assign w_we    = w_is_set && (i_cmd.hit || (i_cmd.miss && r_ins_ok));
    assign w_waddr = i_cmd.hit ? r_chk_idx : r_fill[IDX_W-1:0];

    scs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_val, r_col, r_row}),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Control state: capacity, fill count, scan pointer, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.miss && w_is_set && r_ins_ok) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else if (w_issue) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            r_chk_vld <= w_issue;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= i_req_cmd;
            r_row     <= w_in_row;
            r_col     <= w_in_col;
            r_val     <= i_req_data[VAL_LSB +: VAL_W];
            r_lim     <= CNT_W'(w_lim);
            r_ins_ok  <= (w_fill_ext < w_cap_lim);
            r_res_val <= '0;
            r_res_sts <= STS_RESERVED;
        end
        r_chk_idx <= r_ptr[IDX_W-1:0];
        if (i_cmd.hit) begin
            r_res_sts <= STS_HIT;
            if (!w_is_set) begin
                r_res_val <= w_slot_val;
            end
        end else if (i_cmd.miss) begin
            priority if (!w_is_set) begin
                r_res_sts <= STS_NOT_FOUND;
            end else if (r_ins_ok) begin
                r_res_sts <= STS_INSERTED;
            end else begin
                r_res_sts <= STS_FULL;
            end
        end
        if (i_cmd.emit) begin
            r_out_val <= r_res_val;
            r_out_sts <= r_res_sts;
        end
    end

    // Status to controller
    assign o_sts.reserved  = (w_in_row == '0) && (w_in_col == '0);
    assign o_sts.match     = w_match;
    assign o_sts.exhausted = !r_chk_vld && !(r_ptr < r_lim);
    assign o_sts.out_free  = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid = r_out_vld;
    assign o_rsp_data  = {{OUT_PAD_W{1'b0}}, r_out_sts, r_out_val};

endmodule

FILE: rtl/sparse_coordinate_store_core.sv
// Channel   Dir  Handshake                          Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata row,column,value; tuser command
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata read_value,status
// cfg       in   i_cfg_we (no wait)                 capacity
//
// One slot is compared per cycle through the single registered read port of the slot RAM;
// a reserved key (0,0) takes no search. The slot RAM needs no clearing after reset: slots
// fill from 0 upward, and the fill count bounds the search. A result waiting on m_axis does
// not block acceptance of the next request; that request then holds in its last state until
// the output register is free.
`include "sparse_coordinate_store_core_defines.svh"

module sparse_coordinate_store_core #(
    parameter int DEPTH   = scs_pkg::DEPTH_DEF,
    parameter int COORD_W = scs_pkg::COORD_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [15:0] row, [31:16] column, [95:32] value
    input  logic [scs_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] command
    input  logic                            i_s_axis_tuser,
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [63:0] read_value, [66:64] status, [71:67] zero
    output logic [scs_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [scs_pkg::CAP_W-1:0]       i_cfg_wdata
);

    import scs_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_req_acc;

    scs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    scs_dp #(
        .DEPTH   (DEPTH),
        .COORD_W (COORD_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_data  (i_s_axis_tdata),
        .i_req_cmd   (i_s_axis_tuser),
        .o_rsp_valid (o_m_axis_tvalid),
        .i_rsp_ready (i_m_axis_tready),
        .o_rsp_data  (o_m_axis_tdata)
    );

    // Checks
    assign w_req_acc = i_s_axis_tvalid && o_s_axis_tready;

    `SCS_ASSERT_NEXT(a_one_in_flight, w_req_acc, !o_s_axis_tready, "second request in flight")
    `SCS_ASSERT_NOW(a_emit_free, w_cmd.emit, !o_m_axis_tvalid || i_m_axis_tready, "result overwritten")
    `SCS_ASSERT_NOW(a_rsp_from_emit, $rose(o_m_axis_tvalid), $past(w_cmd.emit), "stray response")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import scs_pkg::*;

    localparam int SLOTS      = DEPTH_DEF;
    localparam int KEY_POOL   = 80;
    localparam int NUM_PHASES = 8;
    localparam int HOLD_CYC   = 400;
    localparam int STALL_LIM  = 3000;
    localparam int TAIL_CYC   = 80;
    localparam int MAX_REPORT = 10;

    typedef enum logic {ROW_REQ, ROW_CAP} t_row_kind;

    // One line of the directed table; val carries the capacity on ROW_CAP
    typedef struct {
        t_row_kind           kind;
        logic                cmd;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [VAL_W-1:0]    val;
        logic                typed;
        logic [VAL_W-1:0]    exp_val;
        logic [STATUS_W-1:0] exp_sts;
    } t_dir_row;

    typedef struct {
        logic [VAL_W-1:0]    rd;
        logic [STATUS_W-1:0] sts;
    } t_entry_result;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CAP_W-1:0]       cfg_wdata = '0;

    // Shadow copy of the slot table and capacity register
    logic [ROW_W-1:0] shadow_row [SLOTS];
    logic [COL_W-1:0] shadow_col [SLOTS];
    logic [VAL_W-1:0] shadow_val [SLOTS];
    logic [CAP_W-1:0] shadow_cap;

    t_entry_result awaited_results[$];
    t_dir_row      directed_tbl[$];

    logic [ROW_W-1:0] pool_row [KEY_POOL];
    logic [COL_W-1:0] pool_col [KEY_POOL];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_asks     = 0;
    int holds_done    = 0;
    int mismatch_cnt  = 0;
    int idle_cycles   = 0;

    // Random phases: capacity, sender idle %, receiver stall %, request count
    int ph_cap   [NUM_PHASES] = '{64, 127, 1, 64, 0, 33, 64, 100};
    int ph_snd   [NUM_PHASES] = '{0, 64, 0, 21, 0, 64, 0, 21};
    int ph_rcv   [NUM_PHASES] = '{0, 0, 64, 21, 0, 0, 64, 21};
    int ph_items [NUM_PHASES] = '{300, 250, 200, 300, 60, 250, 265, 300};

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sparse_coordinate_store_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Table access as the block does it; updates the shadow table on a set
    function automatic t_entry_result coo_access(input logic cmd,
            input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
            input logic [VAL_W-1:0] val);
        t_entry_result res;
        int            lim;
        res.rd = '0;
        if (row == '0 && col == '0) begin
            res.sts = STS_RESERVED;
            return res;
        end
        lim = (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
        res.sts = (cmd == CMD_GET) ? STS_NOT_FOUND : STS_FULL;
        for (int i = 0; i < lim; i++) begin
            if (shadow_row[i] == row && shadow_col[i] == col) begin
                if (cmd == CMD_GET) begin
                    res.rd = shadow_val[i];
                end else begin
                    shadow_val[i] = val;
                end
                res.sts = STS_HIT;
                break;
            end
            // first empty slot takes a new key
            if (cmd == CMD_SET && shadow_row[i] == '0 && shadow_col[i] == '0) begin
                shadow_row[i] = row;
                shadow_col[i] = col;
                shadow_val[i] = val;
                res.sts = STS_INSERTED;
                break;
            end
        end
        return res;
    endfunction

    task automatic dir_req(input logic cmd, input logic [ROW_W-1:0] row,
            input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
            input logic typed, input logic [VAL_W-1:0] exp_val,
            input logic [STATUS_W-1:0] exp_sts);
        t_dir_row d;
        d.kind    = ROW_REQ;
        d.cmd     = cmd;
        d.row     = row;
        d.col     = col;
        d.val     = val;
        d.typed   = typed;
        d.exp_val = exp_val;
        d.exp_sts = exp_sts;
        directed_tbl.push_back(d);
    endtask

    task automatic dir_cap(input logic [CAP_W-1:0] cap);
        t_dir_row d;
        d.kind    = ROW_CAP;
        d.cmd     = CMD_GET;
        d.row     = '0;
        d.col     = '0;
        d.val     = VAL_W'(cap);
        d.typed   = 1'b0;
        d.exp_val = '0;
        d.exp_sts = STS_HIT;
        directed_tbl.push_back(d);
    endtask

    // Offer one request, wait for the handshake, then queue its expected result
    task automatic offer_request(input logic cmd, input logic [ROW_W-1:0] row,
            input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
            input logic typed, input t_entry_result typed_res);
        t_entry_result res;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, col, row};
        do @(posedge clk); while (!s_tready);
        res = coo_access(cmd, row, col, val);
        awaited_results.push_back(typed ? typed_res : res);
    endtask

    // Capacity is only written once the block has drained
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we     <= 1'b0;
        shadow_cap  = cap;
    endtask

    initial begin : stimulus
        t_entry_result    want;
        logic             cmd;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [VAL_W-1:0] v;
        int               sel;
        int               k;

        for (int i = 0; i < SLOTS; i++) begin
            shadow_row[i] = '0;
            shadow_col[i] = '0;
            shadow_val[i] = '0;
        end
        shadow_cap = CAP_RESET;

        // Key pool: half small coordinates, half spread over the full range
        for (int i = 0; i < KEY_POOL; i++) begin
            if (i % 2 == 0) begin
                pool_row[i] = ROW_W'($urandom_range(1, 8));
                pool_col[i] = COL_W'($urandom_range(1, 8));
            end else begin
                pool_row[i] = ROW_W'($urandom_range(65535));
                pool_col[i] = COL_W'($urandom_range(65535));
            end
            if (pool_row[i] == '0 && pool_col[i] == '0) pool_row[i] = 16'd1;
        end

        // Directed table
        dir_req(CMD_GET, 16'd5, 16'd7, '0, 1'b1, '0, STS_NOT_FOUND);
        dir_req(CMD_SET, 16'd0, 16'd0, '1, 1'b1, '0, STS_RESERVED);
        dir_req(CMD_GET, 16'd0, 16'd0, '0, 1'b1, '0, STS_RESERVED);
        dir_req(CMD_SET, 16'd1, 16'd1, '1, 1'b1, '0, STS_INSERTED);
        dir_req(CMD_GET, 16'd1, 16'd1, '0, 1'b1, '1, STS_HIT);
        dir_req(CMD_SET, 16'd1, 16'd1, '0, 1'b1, '0, STS_HIT);
        dir_req(CMD_GET, 16'd1, 16'd1, '1, 1'b1, '0, STS_HIT);
        dir_req(CMD_SET, 16'hFFFF, 16'hFFFF, 64'h8000_0000_0000_0001, 1'b1, '0,
                STS_INSERTED);
        dir_req(CMD_GET, 16'hFFFF, 16'hFFFF, '0, 1'b1, 64'h8000_0000_0000_0001, STS_HIT);
        dir_req(CMD_SET, 16'd0, 16'hFFFF, 64'h5555_5555_5555_5555, 1'b1, '0, STS_INSERTED);
        dir_req(CMD_SET, 16'hFFFF, 16'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '0, STS_INSERTED);
        dir_req(CMD_GET, 16'd0, 16'hFFFF, '0, 1'b1, 64'h5555_5555_5555_5555, STS_HIT);
        dir_req(CMD_GET, 16'hFFFF, 16'd0, '0, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, STS_HIT);
        dir_req(CMD_GET, 16'd1, 16'd2, '0, 1'b1, '0, STS_NOT_FOUND);
        // only slot 0 searched: a key held further up reads as absent
        dir_cap(7'd1);
        dir_req(CMD_SET, 16'd2, 16'd2, '1, 1'b1, '0, STS_FULL);
        dir_req(CMD_GET, 16'hFFFF, 16'hFFFF, '0, 1'b1, '0, STS_NOT_FOUND);
        dir_req(CMD_SET, 16'hFFFF, 16'hFFFF, '1, 1'b1, '0, STS_FULL);
        dir_req(CMD_GET, 16'd1, 16'd1, '0, 1'b1, '0, STS_HIT);
        // nothing searched at all
        dir_cap(7'd0);
        dir_req(CMD_GET, 16'd1, 16'd1, '0, 1'b1, '0, STS_NOT_FOUND);
        dir_req(CMD_SET, 16'd3, 16'd3, '1, 1'b1, '0, STS_FULL);
        dir_req(CMD_GET, 16'd0, 16'd0, '0, 1'b1, '0, STS_RESERVED);
        // above the table size: search clipped to the whole table
        dir_cap(7'd127);
        dir_req(CMD_GET, 16'hFFFF, 16'd0, '0, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, STS_HIT);
        dir_req(CMD_SET, 16'd2, 16'd2, 64'h0123_4567_89AB_CDEF, 1'b1, '0, STS_INSERTED);
        dir_req(CMD_GET, 16'd2, 16'd2, '0, 1'b0, '0, STS_HIT);
        dir_req(CMD_GET, 16'hFFFF, 16'hFFFF, '0, 1'b1, 64'h8000_0000_0000_0001, STS_HIT);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tbl[i]) begin
            if (directed_tbl[i].kind == ROW_CAP) begin
                write_capacity(directed_tbl[i].val[CAP_W-1:0]);
            end else begin
                want.rd  = directed_tbl[i].exp_val;
                want.sts = directed_tbl[i].exp_sts;
                offer_request(directed_tbl[i].cmd, directed_tbl[i].row,
                        directed_tbl[i].col, directed_tbl[i].val,
                        directed_tbl[i].typed, want);
            end
        end

        // Random phases; mostly keys from the pool so hits and updates are common
        want.rd  = '0;
        want.sts = STS_HIT;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(CAP_W'(ph_cap[p]));
            snd_idle_pct  = ph_snd[p];
            rcv_stall_pct = ph_rcv[p];
            if (p == 0) hold_asks++;
            for (int n = 0; n < ph_items[p]; n++) begin
                sel = $urandom_range(99);
                if (sel < 80) begin
                    k = $urandom_range(KEY_POOL - 1);
                    r = pool_row[k];
                    c = pool_col[k];
                end else if (sel < 92) begin
                    r = ROW_W'($urandom_range(65535));
                    c = COL_W'($urandom_range(65535));
                end else if (sel < 95) begin
                    r = '0;
                    c = '0;
                end else if (sel < 97) begin
                    r = '0;
                    c = COL_W'($urandom_range(65535));
                end else begin
                    r = ROW_W'($urandom_range(65535));
                    c = '0;
                end
                cmd = ($urandom_range(1) == 1) ? CMD_SET : CMD_GET;
                v   = {$urandom, $urandom};
                offer_request(cmd, r, c, v, 1'b0, want);
            end
        end

        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
            $display("PASS sparse_coordinate_store_core");
        end else begin
            $display("FAIL sparse_coordinate_store_core");
        end
        $finish;
    end

    // Receiver ready: random stalls, plus one long hold-off on request
    initial begin : sink_ready
        forever begin
            @(posedge clk);
            if (hold_asks != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin : result_check
        t_entry_result exp_res;
        if (rst_n && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORT)
                    $display("unexpected result: tdata %h", m_tdata);
            end else begin
                exp_res = awaited_results.pop_front();
                if (m_tdata[VAL_W-1:0] !== exp_res.rd ||
                        m_tdata[VAL_W +: STATUS_W] !== exp_res.sts ||
                        m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORT)
                        $display("mismatch: read_value exp %h got %h, status exp %0d got %0d",
                                exp_res.rd, m_tdata[VAL_W-1:0], exp_res.sts,
                                m_tdata[VAL_W +: STATUS_W]);
                end
            end
        end
    end

    // Watchdog: too long without any handshake or register write
    always @(posedge clk) begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIM) begin
            $display("FAIL sparse_coordinate_store_core");
            $finish;
        end
    end

endmodule
